// ----- design/gfg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfg_pkg
// Shared types, codes and constants of the GPS fix gate.
// ----------------------------------------------------------------------------
package gfg_pkg;

    localparam int CoordW = 32;            // Q23.8 coordinates
    localparam int RadW   = 24;            // Q16.8 radii
    localparam int SqW    = 2 * RadW;      // squared radius
    localparam int CountW = 8;
    localparam int AddrW  = 4;
    localparam int DataW  = 32;

    localparam logic [RadW-1:0]   InnovRadiusRst  = RadW'(1280);
    localparam logic [RadW-1:0]   StableRadiusRst = RadW'(256);
    localparam logic [CountW-1:0] FixesNeededRst  = CountW'(3);
    localparam logic [CountW-1:0] CountMax        = '1;

    typedef enum logic [1:0] {
        MODE_WAIT     = 2'd0,
        MODE_TRACK    = 2'd1,
        MODE_DEGRADED = 2'd2,
        MODE_RELOC    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_ACCEPT = 2'd1,
        ACT_REJECT = 2'd2,
        ACT_RESET  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CMD_FIX        = 2'd0,
        CMD_TIMEOUT    = 2'd1,
        CMD_RESET_CONF = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_INNOV_RADIUS  = 2'd0,
        REG_STABLE_RADIUS = 2'd1,
        REG_FIXES_NEEDED  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [RadW-1:0]   innov_radius;
        logic [SqW-1:0]    innov_sq;
        logic [RadW-1:0]   stable_radius;
        logic [SqW-1:0]    stable_sq;
        logic [CountW-1:0] fixes_needed;
    } t_cfg;

    typedef struct packed {
        logic [1:0] command;
        logic       fix_valid;
        logic       pred_offered;
        logic       prediction_valid;
        logic       reset_succeeded;
    } t_item_ctl;

    typedef struct packed {
        logic innov_in;    // fix inside innovation radius of prediction
        logic stable_in;   // fix inside stable radius of anchor
    } t_dist_flags;

endpackage

// ----- design/gfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfg_regs
// APB configuration registers; squared radii kept in registers.
// ----------------------------------------------------------------------------
module gfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [gfg_pkg::AddrW-1:0] paddr,
    input  logic [gfg_pkg::DataW-1:0] pwdata,
    output logic [gfg_pkg::DataW-1:0] prdata,
    output logic                      pready,
    output gfg_pkg::t_cfg             o_cfg
);
    import gfg_pkg::*;

    logic [RadW-1:0]   r_innov_radius;
    logic [RadW-1:0]   r_stable_radius;
    logic [CountW-1:0] r_fixes_needed;
    logic [SqW-1:0]    r_innov_sq;
    logic [SqW-1:0]    r_stable_sq;
    logic              w_wr;
    t_reg_idx          w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = t_reg_idx'(paddr[AddrW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_innov_radius  <= InnovRadiusRst;
            r_stable_radius <= StableRadiusRst;
            r_fixes_needed  <= FixesNeededRst;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_INNOV_RADIUS:  r_innov_radius  <= pwdata[RadW-1:0];
                REG_STABLE_RADIUS: r_stable_radius <= pwdata[RadW-1:0];
                REG_FIXES_NEEDED:  r_fixes_needed  <= pwdata[CountW-1:0];
                default: ;
            endcase
        end
    end

    // squares are registered and follow the radii in the next cycle
    always_ff @(posedge i_clk) begin
        r_innov_sq  <= SqW'(r_innov_radius) * SqW'(r_innov_radius);
        r_stable_sq <= SqW'(r_stable_radius) * SqW'(r_stable_radius);
    end

    always_comb begin
        unique case (w_idx)
            REG_INNOV_RADIUS:  prdata = DataW'(r_innov_radius);
            REG_STABLE_RADIUS: prdata = DataW'(r_stable_radius);
            REG_FIXES_NEEDED:  prdata = DataW'(r_fixes_needed);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.innov_radius  = r_innov_radius;
    assign o_cfg.innov_sq      = r_innov_sq;
    assign o_cfg.stable_radius = r_stable_radius;
    assign o_cfg.stable_sq     = r_stable_sq;
    assign o_cfg.fixes_needed  = r_fixes_needed;

endmodule

// ----- design/gfg_dist.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfg_dist
// Planar radius test on squared distances: |dx|,|dy| <= r and dx^2+dy^2 <= r^2.
// ----------------------------------------------------------------------------
module gfg_dist (
    input  logic [gfg_pkg::CoordW-1:0] i_ax,
    input  logic [gfg_pkg::CoordW-1:0] i_ay,
    input  logic [gfg_pkg::CoordW-1:0] i_bx,
    input  logic [gfg_pkg::CoordW-1:0] i_by,
    input  logic [gfg_pkg::RadW-1:0]   i_radius,
    input  logic [gfg_pkg::SqW-1:0]    i_radius_sq,
    output logic                       o_within
);
    import gfg_pkg::*;

    logic [CoordW:0] w_dx, w_dy, w_adx, w_ady;
    logic            w_x_ok, w_y_ok;
    logic [SqW-1:0]  w_sqx, w_sqy;
    logic [SqW:0]    w_sum;

    // 33-bit differences of sign-extended operands, top bit is the sign
    assign w_dx  = {i_ax[CoordW-1], i_ax} - {i_bx[CoordW-1], i_bx};
    assign w_dy  = {i_ay[CoordW-1], i_ay} - {i_by[CoordW-1], i_by};
    assign w_adx = w_dx[CoordW] ? (CoordW+1)'(-w_dx) : w_dx;
    assign w_ady = w_dy[CoordW] ? (CoordW+1)'(-w_dy) : w_dy;

    assign w_x_ok = (w_adx[CoordW:RadW] == '0) && (w_adx[RadW-1:0] <= i_radius);
    assign w_y_ok = (w_ady[CoordW:RadW] == '0) && (w_ady[RadW-1:0] <= i_radius);

    // squares only matter when both components fit the radius width
    assign w_sqx = SqW'(w_adx[RadW-1:0]) * SqW'(w_adx[RadW-1:0]);
    assign w_sqy = SqW'(w_ady[RadW-1:0]) * SqW'(w_ady[RadW-1:0]);
    assign w_sum = {1'b0, w_sqx} + {1'b0, w_sqy};

    assign o_within = w_x_ok && w_y_ok && (w_sum <= {1'b0, i_radius_sq});

endmodule

// ----- design/gfg_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfg_fsm
// Gate state machine: mode, stable-fix counter, anchor and reset flags.
// ----------------------------------------------------------------------------
module gfg_fsm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  gfg_pkg::t_item_ctl          i_ctl,
    input  logic [gfg_pkg::CoordW-1:0]  i_fix_x,
    input  logic [gfg_pkg::CoordW-1:0]  i_fix_y,
    input  gfg_pkg::t_dist_flags        i_flags,
    input  logic [gfg_pkg::CountW-1:0]  i_fixes_needed,
    output logic [gfg_pkg::CoordW-1:0]  o_anchor_x,
    output logic [gfg_pkg::CoordW-1:0]  o_anchor_y,
    output gfg_pkg::t_action            o_action,
    output gfg_pkg::t_mode              o_mode
);
    import gfg_pkg::*;

    t_mode             r_mode, n_mode;
    logic [CountW-1:0] r_count, n_count;
    logic [CoordW-1:0] r_anchor_x, n_anchor_x;
    logic [CoordW-1:0] r_anchor_y, n_anchor_y;
    logic              r_jump, n_jump;
    logic              r_rst_wait, n_rst_wait;

    t_cmd              w_cmd;
    logic              w_innov_ok;
    logic              w_jump;
    logic              w_restart;
    logic              w_tail;
    logic              w_pass;
    logic [CountW-1:0] w_cnt_mid;
    logic              w_jump_mid;

    assign w_cmd      = t_cmd'(i_ctl.command);
    assign w_innov_ok = i_ctl.prediction_valid && i_flags.innov_in;
    assign w_jump     = i_ctl.pred_offered && !w_innov_ok;

    // relocalization bookkeeping shared by next-state and output logic
    always_comb begin
        w_restart  = 1'b0;
        w_tail     = 1'b0;
        w_cnt_mid  = r_count;
        w_jump_mid = r_jump;
        if (w_cmd == CMD_FIX && i_ctl.fix_valid) begin
            if (r_mode == MODE_DEGRADED && w_jump) begin
                w_restart = 1'b1;
                w_tail    = 1'b1;
            end else if (r_mode == MODE_DEGRADED && !i_ctl.pred_offered) begin
                w_restart = 1'b1;
                w_tail    = 1'b1;
            end else if (r_mode == MODE_RELOC) begin
                w_tail = 1'b1;
                if (i_flags.stable_in) begin
                    w_jump_mid = r_jump | w_jump;
                    w_cnt_mid  = (r_count == CountMax) ? r_count : r_count + 1'b1;
                end else begin
                    w_restart = 1'b1;
                end
            end
            if (w_restart) begin
                w_cnt_mid  = CountW'(1);
                w_jump_mid = w_jump;
            end
        end
        w_pass = (w_cnt_mid >= i_fixes_needed);
    end

    // next state
    always_comb begin
        n_mode     = r_mode;
        n_count    = r_count;
        n_anchor_x = r_anchor_x;
        n_anchor_y = r_anchor_y;
        n_jump     = r_jump;
        n_rst_wait = r_rst_wait;
        unique case (w_cmd)
            CMD_FIX: begin
                if (i_ctl.fix_valid) begin
                    if (r_mode == MODE_WAIT) begin
                        n_mode = MODE_TRACK;
                    end else if (r_mode == MODE_DEGRADED && !w_restart) begin
                        n_mode = MODE_TRACK;
                    end
                    if (w_restart) begin
                        n_mode     = MODE_RELOC;
                        n_anchor_x = i_fix_x;
                        n_anchor_y = i_fix_y;
                        n_rst_wait = 1'b0;
                    end
                    if (w_tail) begin
                        n_count = w_cnt_mid;
                        n_jump  = w_jump_mid;
                        if (w_pass && w_jump_mid) begin
                            n_rst_wait = 1'b1;
                        end else if (w_pass) begin
                            n_mode     = MODE_TRACK;
                            n_count    = '0;
                            n_rst_wait = 1'b0;
                        end
                    end
                end
            end
            CMD_TIMEOUT: begin
                n_mode     = MODE_DEGRADED;
                n_count    = '0;
                n_jump     = 1'b0;
                n_rst_wait = 1'b0;
            end
            CMD_RESET_CONF: begin
                if (i_ctl.reset_succeeded && r_mode == MODE_RELOC && r_rst_wait) begin
                    n_mode     = MODE_TRACK;
                    n_count    = '0;
                    n_jump     = 1'b0;
                    n_rst_wait = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_action = ACT_NONE;
        if (w_cmd == CMD_FIX) begin
            if (!i_ctl.fix_valid) begin
                o_action = ACT_REJECT;
            end else if (w_tail) begin
                if (!w_pass) begin
                    o_action = ACT_REJECT;
                end else if (w_jump_mid) begin
                    o_action = ACT_RESET;
                end else begin
                    o_action = ACT_ACCEPT;
                end
            end else if (r_mode == MODE_TRACK && w_jump) begin
                o_action = ACT_REJECT;
            end else begin
                o_action = ACT_ACCEPT;
            end
        end
    end

    assign o_mode     = n_mode;
    assign o_anchor_x = r_anchor_x;
    assign o_anchor_y = r_anchor_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_WAIT;
            r_count    <= '0;
            r_anchor_x <= '0;
            r_anchor_y <= '0;
            r_jump     <= 1'b0;
            r_rst_wait <= 1'b0;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_count    <= n_count;
            r_anchor_x <= n_anchor_x;
            r_anchor_y <= n_anchor_y;
            r_jump     <= n_jump;
            r_rst_wait <= n_rst_wait;
        end
    end

endmodule

// ----- design/gps_fix_gate_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_fix_gate_fsm
// GPS fix gate: waiting / tracking / degraded / relocalizing decisions.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-------------------------------------
//  input    | i_in_valid / o_in_ready    | i_command, i_fix_*, i_pred_*, flags
//  result   | o_out_valid / i_out_ready  | o_action, o_gate_mode
//  config   | psel, penable, pwrite      | paddr, pwdata, prdata (pready = 1)
//
//  One item per cycle while the result side is not stalled: an item lands in
//  the input register on its transfer, is evaluated there (two radius tests
//  plus the state machine) and moves to the result register, which drives
//  o_out_valid.
//  The input register frees whenever the result register is empty or being
//  taken, so a stalled result still lets one more item in.
//  Reset is synchronous, active low; state and config registers return to
//  reset values and both pipeline slots empty.
//  Radius changes reach the squared-radius registers in the cycle after the
//  radius register is written.
// ----------------------------------------------------------------------------
module gps_fix_gate_fsm (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input items
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_command,
    input  logic                      i_fix_valid,
    input  logic [gfg_pkg::CoordW-1:0] i_fix_x,
    input  logic [gfg_pkg::CoordW-1:0] i_fix_y,
    input  logic                      i_pred_offered,
    input  logic                      i_prediction_valid,
    input  logic [gfg_pkg::CoordW-1:0] i_pred_x,
    input  logic [gfg_pkg::CoordW-1:0] i_pred_y,
    input  logic                      i_reset_succeeded,
    // results
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_action,
    output logic [1:0]                o_gate_mode,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [gfg_pkg::AddrW-1:0] paddr,
    input  logic [gfg_pkg::DataW-1:0] pwdata,
    output logic [gfg_pkg::DataW-1:0] prdata,
    output logic                      pready
);
    import gfg_pkg::*;

    // input register
    logic              r_in_valid;
    t_item_ctl         r_ctl;
    logic [CoordW-1:0] r_fix_x, r_fix_y;
    logic [CoordW-1:0] r_pred_x, r_pred_y;

    // result register
    logic              r_out_valid;
    logic [1:0]        r_action;
    logic [1:0]        r_gate_mode;

    logic              w_in_xfer;
    logic              w_step;
    t_cfg              w_cfg;
    t_dist_flags       w_flags;
    logic [CoordW-1:0] w_anchor_x, w_anchor_y;
    t_action           w_action;
    t_mode             w_mode;

    // item is evaluated when its result has somewhere to go
    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_ctl.command          <= i_command;
            r_ctl.fix_valid        <= i_fix_valid;
            r_ctl.pred_offered     <= i_pred_offered;
            r_ctl.prediction_valid <= i_prediction_valid;
            r_ctl.reset_succeeded  <= i_reset_succeeded;
            r_fix_x                <= i_fix_x;
            r_fix_y                <= i_fix_y;
            r_pred_x               <= i_pred_x;
            r_pred_y               <= i_pred_y;
        end
    end

    gfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // innovation test: fix against prediction
    gfg_dist u_dist_innov (
        .i_ax        (r_fix_x),
        .i_ay        (r_fix_y),
        .i_bx        (r_pred_x),
        .i_by        (r_pred_y),
        .i_radius    (w_cfg.innov_radius),
        .i_radius_sq (w_cfg.innov_sq),
        .o_within    (w_flags.innov_in)
    );

    // stability test: fix against relocalization anchor
    gfg_dist u_dist_stable (
        .i_ax        (r_fix_x),
        .i_ay        (r_fix_y),
        .i_bx        (w_anchor_x),
        .i_by        (w_anchor_y),
        .i_radius    (w_cfg.stable_radius),
        .i_radius_sq (w_cfg.stable_sq),
        .o_within    (w_flags.stable_in)
    );

    gfg_fsm u_fsm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_ctl          (r_ctl),
        .i_fix_x        (r_fix_x),
        .i_fix_y        (r_fix_y),
        .i_flags        (w_flags),
        .i_fixes_needed (w_cfg.fixes_needed),
        .o_anchor_x     (w_anchor_x),
        .o_anchor_y     (w_anchor_y),
        .o_action       (w_action),
        .o_mode         (w_mode)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_action    <= w_action;
            r_gate_mode <= w_mode;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_action    = r_action;
    assign o_gate_mode = r_gate_mode;

endmodule

// ----- design/gfg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfg_checker
// Port-level checks on the GPS fix gate, bound to the top level.
// ----------------------------------------------------------------------------
module gfg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_action,
    input logic [1:0] o_gate_mode
);
    import gfg_pkg::*;

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_action) && $stable(o_gate_mode))
        else $error("result changed while stalled");

    // every accept leaves the gate tracking
    a_accept_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == ACT_ACCEPT |-> o_gate_mode == MODE_TRACK)
        else $error("accept outside tracking");

    // reset-filter only while relocalizing
    a_reset_reloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == ACT_RESET |-> o_gate_mode == MODE_RELOC)
        else $error("reset filter outside relocalization");

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind gps_fix_gate_fsm gfg_checker u_gfg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_action    (o_action),
    .o_gate_mode (o_gate_mode)
);
